// ----- rtl/tls_pkg.sv -----
// Shared types and constants for the thread and lock scheduler.
// Used by tls_ready_queue and thread_lock_scheduler; depends on nothing.
package tls_pkg;

  localparam int SLOTS  = 32;
  localparam int ID_W   = 5;
  localparam int CNT_W  = 6;
  localparam int FILL_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

  typedef enum logic [2:0] {
    REQ_CREATE,
    REQ_YIELD,
    REQ_EXIT,
    REQ_JOIN,
    REQ_INIT,
    REQ_LOCK,
    REQ_UNLOCK,
    REQ_DESTROY
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_SCAN,
    ST_FETCH,
    ST_SCHED,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [ID_W-1:0] target_id;
  } req_t;

  typedef struct packed {
    logic            status;
    logic [ID_W-1:0] handle;
    logic [ID_W-1:0] running_thread;
    logic            running_valid;
  } rsp_t;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] push_id;
  } rq_ctl_t;

  typedef struct packed {
    logic [ID_W-1:0] thread;
    logic [ID_W-1:0] target;
  } wait_entry_t;

endpackage

// ----- rtl/tls_ready_queue.sv -----
// Circular FIFO of ready thread ids in a synchronous memory.
// Depends on tls_pkg. The head entry is read out registered every cycle.
module tls_ready_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  tls_pkg::rq_ctl_t              ctl,
  output logic [tls_pkg::FILL_W-1:0]    fill,
  output logic [tls_pkg::ID_W-1:0]      head_id
);

  logic [tls_pkg::ID_W-1:0]   mem [tls_pkg::SLOTS];
  logic [tls_pkg::ID_W-1:0]   head;
  logic [tls_pkg::ID_W-1:0]   head_next;
  logic [tls_pkg::FILL_W-1:0] fill_next;
  logic                       we;
  logic [tls_pkg::ID_W-1:0]   waddr;

  always_comb begin
    head_next = head;
    fill_next = fill;
    we        = 1'b0;
    waddr     = head + fill[tls_pkg::ID_W-1:0];
    case ({ctl.pop, ctl.push})
      2'b10: begin
        head_next = head + tls_pkg::ID_W'(1);
        fill_next = fill - tls_pkg::FILL_W'(1);
      end
      2'b11: begin
        // pop frees a place, so the push always lands
        head_next = head + tls_pkg::ID_W'(1);
        we        = 1'b1;
      end
      2'b01: begin
        if (fill < tls_pkg::FILL_W'(tls_pkg::SLOTS)) begin
          we        = 1'b1;
          fill_next = fill + tls_pkg::FILL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= ctl.push_id;
    end
    head_id <= mem[head];
  end

endmodule

// ----- rtl/thread_lock_scheduler.sv -----
// Thread and lock scheduler: one request beat in, one response beat out.
// Request beat: req_type and target_id. Response beat: status, handle of a
// newly allocated slot, and the thread running after the request.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. One request is processed at a time; req_stall is high from the
// accepting edge until the response is registered.
// From the accepting edge a request passes the LOOK, EXEC and DONE states;
// yield and a blocking join or lock also pass FETCH and SCHED, where the
// ready queue is popped if it holds a thread. Exit of a running thread, and
// an unlock that leaves the lock count nonzero, sweep the wait list one entry
// per cycle through the wait memory port in SCAN; exit then goes on to FETCH
// and SCHED. The next request is accepted, at the earliest, in the cycle after the response is loaded.
// The response sits in an output register; the next request is taken while
// it waits, but a second response holds until rsp_stall drops.
// Reset clears the slot table, empties the ready queue and wait list and
// makes the main thread (id 0) the running thread. No sweep follows reset.
// Depends on tls_pkg and tls_ready_queue.
module thread_lock_scheduler (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tls_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tls_pkg::rsp_t rsp
);

  tls_pkg::state_t    state, state_next;
  tls_pkg::req_kind_t kind;
  logic [tls_pkg::ID_W-1:0] tgt;

  logic [tls_pkg::SLOTS-1:0] used;
  logic [tls_pkg::CNT_W-1:0] cnt_mem [tls_pkg::SLOTS];
  logic [tls_pkg::CNT_W-1:0] cnt_rdata;
  logic                      cnt_we;
  logic [tls_pkg::ID_W-1:0]  cnt_waddr;
  logic [tls_pkg::CNT_W-1:0] cnt_wdata;

  tls_pkg::wait_entry_t      wait_mem [tls_pkg::SLOTS];
  tls_pkg::wait_entry_t      wait_rdata;
  tls_pkg::wait_entry_t      wait_wdata;
  logic                      wait_we;
  logic [tls_pkg::ID_W-1:0]  wait_waddr;
  logic [tls_pkg::FILL_W-1:0] wfill;

  logic [tls_pkg::ID_W-1:0]  cur_thread;
  logic                      cur_valid;
  logic                      blocking;
  logic                      res_status;
  logic [tls_pkg::ID_W-1:0]  res_handle;

  logic [tls_pkg::FILL_W-1:0] scan_rd;
  logic [tls_pkg::FILL_W-1:0] scan_wr;
  logic                      scan_pend;
  logic                      scan_removed;
  logic                      scan_all;
  logic [tls_pkg::ID_W-1:0]  scan_tgt;
  logic                      scan_end;
  logic                      scan_match;

  tls_pkg::rq_ctl_t          rq_ctl;
  logic [tls_pkg::FILL_W-1:0] rq_fill;
  logic [tls_pkg::ID_W-1:0]  rq_head_id;

  logic                      free_ok;
  logic [tls_pkg::ID_W-1:0]  free_id;
  logic                      tgt_ok;
  logic                      can_block;
  logic                      rsp_load;

  tls_ready_queue u_ready (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rq_ctl),
    .fill    (rq_fill),
    .head_id (rq_head_id)
  );

  // lowest free slot, slot 0 excluded
  always_comb begin
    free_ok = 1'b0;
    free_id = '0;
    for (int i = tls_pkg::SLOTS - 1; i >= 1; i--) begin
      if (!used[i]) begin
        free_ok = 1'b1;
        free_id = tls_pkg::ID_W'(i);
      end
    end
  end

  assign tgt_ok     = used[tgt];
  assign can_block  = cur_valid && (rq_fill != '0) &&
                      (wfill < tls_pkg::FILL_W'(tls_pkg::SLOTS));
  assign scan_end   = !scan_pend && (scan_rd >= wfill);
  assign scan_match = scan_pend && (wait_rdata.target == scan_tgt) &&
                      (scan_all || !scan_removed);
  assign rsp_load   = (state == tls_pkg::ST_DONE) && (!rsp_valid || !rsp_stall);
  assign req_stall  = (state != tls_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tls_pkg::ST_IDLE:  if (req_valid) state_next = tls_pkg::ST_LOOK;
      tls_pkg::ST_LOOK:  state_next = tls_pkg::ST_EXEC;
      tls_pkg::ST_EXEC: begin
        case (kind)
          tls_pkg::REQ_YIELD: state_next = tls_pkg::ST_FETCH;
          tls_pkg::REQ_EXIT:
            state_next = cur_valid ? tls_pkg::ST_SCAN : tls_pkg::ST_DONE;
          tls_pkg::REQ_JOIN, tls_pkg::REQ_LOCK:
            state_next = (tgt_ok && cnt_rdata != '0 && can_block) ?
                         tls_pkg::ST_FETCH : tls_pkg::ST_DONE;
          tls_pkg::REQ_UNLOCK:
            state_next = (tgt_ok && cnt_rdata > tls_pkg::CNT_W'(1)) ?
                         tls_pkg::ST_SCAN : tls_pkg::ST_DONE;
          default: state_next = tls_pkg::ST_DONE;
        endcase
      end
      tls_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = (kind == tls_pkg::REQ_EXIT) ? tls_pkg::ST_FETCH : tls_pkg::ST_DONE;
        end
      end
      tls_pkg::ST_FETCH: state_next = tls_pkg::ST_SCHED;
      tls_pkg::ST_SCHED: state_next = tls_pkg::ST_DONE;
      tls_pkg::ST_DONE:  if (rsp_load) state_next = tls_pkg::ST_IDLE;
      default:           state_next = tls_pkg::ST_IDLE;
    endcase
  end

  // memory and queue controls
  always_comb begin
    rq_ctl     = '0;
    cnt_we     = 1'b0;
    cnt_waddr  = tgt;
    cnt_wdata  = '0;
    wait_we    = 1'b0;
    wait_waddr = wfill[tls_pkg::ID_W-1:0];
    wait_wdata = '{thread: cur_thread, target: tgt};
    case (state)
      tls_pkg::ST_EXEC: begin
        case (kind)
          tls_pkg::REQ_CREATE, tls_pkg::REQ_INIT: begin
            if (free_ok) begin
              cnt_we         = 1'b1;
              cnt_waddr      = free_id;
              cnt_wdata      = (kind == tls_pkg::REQ_CREATE) ? tls_pkg::CNT_W'(1) : '0;
              rq_ctl.push    = (kind == tls_pkg::REQ_CREATE);
              rq_ctl.push_id = free_id;
            end
          end
          tls_pkg::REQ_JOIN, tls_pkg::REQ_LOCK: begin
            if (tgt_ok) begin
              cnt_we = 1'b1;
              if (cnt_rdata == '0) begin
                cnt_wdata = tls_pkg::CNT_W'(1);
              end else begin
                cnt_wdata = (cnt_rdata == tls_pkg::CNT_MAX) ? tls_pkg::CNT_MAX :
                            cnt_rdata + tls_pkg::CNT_W'(1);
                wait_we   = can_block;
              end
            end
          end
          tls_pkg::REQ_UNLOCK: begin
            if (tgt_ok && cnt_rdata != '0) begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rdata - tls_pkg::CNT_W'(1);
            end
          end
          tls_pkg::REQ_DESTROY: begin
            cnt_we = tgt_ok;
          end
          default: begin
          end
        endcase
      end
      tls_pkg::ST_SCAN: begin
        // compact the wait list in place, waking matches
        if (scan_match) begin
          rq_ctl.push    = 1'b1;
          rq_ctl.push_id = wait_rdata.thread;
        end else if (scan_pend) begin
          wait_we    = 1'b1;
          wait_waddr = scan_wr[tls_pkg::ID_W-1:0];
          wait_wdata = wait_rdata;
        end
        if (scan_end && kind == tls_pkg::REQ_EXIT) begin
          cnt_we    = 1'b1;
          cnt_waddr = cur_thread;
        end
      end
      tls_pkg::ST_SCHED: begin
        if (rq_fill != '0) begin
          rq_ctl.pop     = 1'b1;
          rq_ctl.push    = cur_valid && !blocking;
          rq_ctl.push_id = cur_thread;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[tgt];
    if (wait_we) begin
      wait_mem[wait_waddr] <= wait_wdata;
    end
    wait_rdata <= wait_mem[scan_rd[tls_pkg::ID_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tls_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      wfill      <= '0;
      cur_thread <= '0;
      cur_valid  <= 1'b1;
      scan_pend  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        tls_pkg::ST_IDLE: begin
          if (req_valid) begin
            kind     <= tls_pkg::req_kind_t'(req.req_type);
            tgt      <= req.target_id;
            blocking <= 1'b0;
          end
        end
        tls_pkg::ST_EXEC: begin
          res_status   <= 1'b0;
          res_handle   <= '0;
          scan_rd      <= '0;
          scan_wr      <= '0;
          scan_pend    <= 1'b0;
          scan_removed <= 1'b0;
          case (kind)
            tls_pkg::REQ_CREATE, tls_pkg::REQ_INIT: begin
              if (free_ok) begin
                used[free_id] <= 1'b1;
                res_handle    <= free_id;
              end else begin
                res_status <= 1'b1;
              end
            end
            tls_pkg::REQ_EXIT: begin
              res_status <= !cur_valid;
              scan_tgt   <= cur_thread;
              scan_all   <= 1'b1;
            end
            tls_pkg::REQ_JOIN, tls_pkg::REQ_LOCK: begin
              if (!tgt_ok) begin
                res_status <= 1'b1;
              end else if (cnt_rdata != '0 && can_block) begin
                wfill    <= wfill + tls_pkg::FILL_W'(1);
                blocking <= 1'b1;
              end
            end
            tls_pkg::REQ_UNLOCK: begin
              res_status <= !tgt_ok || (cnt_rdata == '0);
              scan_tgt   <= tgt;
              scan_all   <= 1'b0;
            end
            tls_pkg::REQ_DESTROY: begin
              if (tgt_ok) begin
                used[tgt] <= 1'b0;
              end else begin
                res_status <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        tls_pkg::ST_SCAN: begin
          scan_pend <= (scan_rd < wfill);
          if (scan_rd < wfill) begin
            scan_rd <= scan_rd + tls_pkg::FILL_W'(1);
          end
          if (scan_match) begin
            scan_removed <= 1'b1;
          end else if (scan_pend) begin
            scan_wr <= scan_wr + tls_pkg::FILL_W'(1);
          end
          if (scan_end) begin
            wfill <= scan_wr;
            if (kind == tls_pkg::REQ_EXIT) begin
              used[cur_thread] <= 1'b0;
              cur_valid        <= 1'b0;
            end
          end
        end
        tls_pkg::ST_SCHED: begin
          if (rq_fill != '0) begin
            cur_thread <= rq_head_id;
            cur_valid  <= 1'b1;
          end
        end
        tls_pkg::ST_DONE: begin
          if (rsp_load) begin
            rsp_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status         <= res_status;
      rsp.handle         <= res_handle;
      rsp.running_thread <= cur_valid ? cur_thread : '0;
      rsp.running_valid  <= cur_valid;
    end
  end

`ifndef SYNTHESIS
  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_fill <= tls_pkg::FILL_W'(tls_pkg::SLOTS))
    else $error("ready queue fill out of range");

  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    wfill <= tls_pkg::FILL_W'(tls_pkg::SLOTS))
    else $error("wait list fill out of range");

  a_sched_runs: assert property (@(posedge clk) disable iff (rst)
    (state == tls_pkg::ST_SCHED) && (rq_fill != '0) |=> cur_valid)
    else $error("pop from ready queue left no running thread");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> rsp_valid && (state == tls_pkg::ST_IDLE))
    else $error("response not presented after completion");
`endif

endmodule
